@@ rtl/chb_pkg.sv @@
`timescale 1ns / 1ps

package chb_pkg;

   // field widths
   localparam int TEMP_W     = 20;
   localparam int ERR_W      = 21;
   localparam int GAIN_W     = 24;
   localparam int OFFSET_W   = 16;
   localparam int PULSE_W    = 22;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_COARSE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_FINE   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REAR_OFFSET = 3'd4;

   // pulse limits: heat time cap is the largest ms value that gives 4095 s
   localparam logic [PULSE_W-1:0] PULSE_MAX    = 22'h3FFFFF;
   localparam logic [PULSE_W-1:0] HEAT_CAP_MAX = 22'd4095999;

   // output codes of the phase field
   localparam logic [1:0] PHASE_CODE_COMPUTE = 2'd0;
   localparam logic [1:0] PHASE_CODE_HEAT    = 2'd1;
   localparam logic [1:0] PHASE_CODE_COOL    = 2'd2;

   typedef enum logic [2:0] {
      PH_COMPUTE = 3'b001,
      PH_HEAT    = 3'b010,
      PH_COOL    = 3'b100
   } phase_type;

   typedef enum logic [2:0] {
      TR_FAST_FALL = 3'd0,
      TR_SLOW_FALL = 3'd1,
      TR_STEADY    = 3'd2,
      TR_SLOW_RISE = 3'd3,
      TR_FAST_RISE = 3'd4,
      TR_UNDET     = 3'd5
   } trend_type;

   typedef struct packed {
      logic [TEMP_W-1:0]   setpoint;
      logic                enable;
      logic [GAIN_W-1:0]   gain_coarse;
      logic [GAIN_W-1:0]   gain_fine;
      logic [OFFSET_W-1:0] rear_offset;
   } cfg_type;

   typedef struct packed {
      phase_type          phase;
      logic [15:0]        elapsed;
      logic [PULSE_W-1:0] heat_cap;
      logic [6:0]         cool;
      logic               overshoot;
      logic [7:0]         integral;
      logic [7:0]         escalation;
      logic [7:0]         cycle;
      logic               region;
      logic [7:0]         slow_rise;
      logic [7:0]         no_rise;
      logic [TEMP_W-1:0]  reference;
      logic               pending;
      trend_type          trend;
      logic [5:0]         stable;
   } state_type;

   typedef struct packed {
      logic [PULSE_W-1:0] main_ms;
      logic [PULSE_W-1:0] rear_ms;
      logic               heaters_off;
      logic [1:0]         phase;
      logic [2:0]         trend;
      logic [7:0]         integral;
      logic [5:0]         stable;
   } rsp_type;

endpackage

@@ rtl/chb_csr.sv @@
`timescale 1ns / 1ps

module chb_csr import chb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  csr_ready,
   output cfg_type               cfg_o
);

   cfg_type cfg_ff;

   // writes always taken
   assign csr_ready = 1'b1;
   assign cfg_o     = cfg_ff;

   // register file, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SETPOINT:    cfg_ff.setpoint    <= csr_wdata[TEMP_W-1:0];
            CSR_ENABLE:      cfg_ff.enable      <= csr_wdata[0];
            CSR_GAIN_COARSE: cfg_ff.gain_coarse <= csr_wdata[GAIN_W-1:0];
            CSR_GAIN_FINE:   cfg_ff.gain_fine   <= csr_wdata[GAIN_W-1:0];
            CSR_REAR_OFFSET: cfg_ff.rear_offset <= csr_wdata[OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

@@ rtl/chb_pulse.sv @@
`timescale 1ns / 1ps

module chb_pulse import chb_pkg::*; (
   input  logic signed [ERR_W-1:0] err_i,
   input  logic                    coarse_i,
   input  cfg_type                 cfg_i,
   input  logic [7:0]              escalation_i,
   input  logic [7:0]              integral_i,
   output logic [PULSE_W-1:0]      heat_ms_o,
   output logic [PULSE_W-1:0]      rear_ms_o,
   output logic [PULSE_W-1:0]      heat_cap_o
);

   logic signed [ERR_W-1:0] a_full;
   logic [19:0]             a_op;
   logic [GAIN_W-1:0]       gain;
   logic [16:0]             bias;
   logic [43:0]             prod;
   logic [34:0]             sum;
   logic [22:0]             rear_sum;

   // error above the coarse knee or plain error, with the matching gain
   assign a_full = coarse_i ? err_i - 21'sd500 : err_i;
   assign a_op   = a_full[19:0];
   assign gain   = coarse_i ? cfg_i.gain_coarse : cfg_i.gain_fine;

   // escalation or clamped integral, 500 ms per unit
   always_comb begin
      if (coarse_i) begin
         bias = {9'b0, escalation_i} * 17'd500;
      end else if (integral_i[7]) begin
         bias = '0;
      end else begin
         bias = {10'b0, integral_i[6:0]} * 17'd500;
      end
   end

   assign prod = {24'b0, a_op} * {20'b0, gain};
   assign sum  = {1'b0, prod[43:10]} + {18'b0, bias};

   // saturate pulses
   assign heat_ms_o  = (sum > {13'b0, PULSE_MAX}) ? PULSE_MAX : sum[PULSE_W-1:0];
   assign rear_sum   = {1'b0, heat_ms_o} + {7'b0, cfg_i.rear_offset};
   assign rear_ms_o  = (rear_sum > {1'b0, PULSE_MAX}) ? PULSE_MAX : rear_sum[PULSE_W-1:0];
   assign heat_cap_o = (heat_ms_o > HEAT_CAP_MAX) ? HEAT_CAP_MAX : heat_ms_o;

endmodule

@@ rtl/chb_step.sv @@
`timescale 1ns / 1ps

module chb_step import chb_pkg::*; (
   input  cfg_type                 cfg_i,
   input  state_type               state_i,
   input  logic [TEMP_W-1:0]       temp_i,
   input  logic signed [ERR_W-1:0] err_i,
   input  logic                    restart_i,
   input  logic                    clear_i,
   output state_type               state_o,
   output rsp_type                 rsp_o
);

   logic signed [ERR_W-1:0] drift;
   logic                    err_coarse;
   logic                    err_neg;
   logic                    err_pos;
   logic                    near_set;
   logic [PULSE_W-1:0]      heat_ms;
   logic [PULSE_W-1:0]      rear_ms;
   logic [PULSE_W-1:0]      heat_cap;
   logic [10:0]             dc;
   logic [11:0]             nc;
   logic [23:0]             pc;
   logic [6:0]              coarse_cool;
   logic [11:0]             nf;
   logic [23:0]             pf;
   logic [6:0]              fine_cool;
   logic [25:0]             elapsed_ms;
   logic                    heat_time_up;
   logic                    from_compute;

   function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [3:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {5'b0, b};
      return s[8] ? 8'hFF : s[7:0];
   endfunction

   function automatic logic [1:0] phase_code(input phase_type p);
      logic [1:0] c;
      case (p)
         PH_COMPUTE: c = PHASE_CODE_COMPUTE;
         PH_HEAT:    c = PHASE_CODE_HEAT;
         PH_COOL:    c = PHASE_CODE_COOL;
         default:    c = PHASE_CODE_COOL;
      endcase
      return c;
   endfunction

   // error classes
   assign err_coarse = err_i > 21'sd500;
   assign err_neg    = err_i < 21'sd0;
   assign err_pos    = err_i > 21'sd0;
   assign near_set   = (err_i >= -21'sd250) && (err_i <= 21'sd250);

   // change since the sampled reference
   assign drift = $signed({state_i.reference[TEMP_W-1], state_i.reference})
                  - $signed({temp_i[TEMP_W-1], temp_i});

   chb_pulse u_pulse (
      .err_i        (err_i),
      .coarse_i     (err_coarse),
      .cfg_i        (cfg_i),
      .escalation_i (state_i.escalation),
      .integral_i   (state_i.integral),
      .heat_ms_o    (heat_ms),
      .rear_ms_o    (rear_ms),
      .heat_cap_o   (heat_cap)
   );

   // coarse cool time 3*(err-1000)/25 for err 1500..2000, 60 below, 120 above
   assign dc          = 11'(err_i - 21'sd1000);
   assign nc          = {1'b0, dc} * 12'd3;
   assign pc          = {12'b0, nc} * 24'd2622;
   assign coarse_cool = (err_i > 21'sd2000) ? 7'd120 :
                        (err_i >= 21'sd1500) ? pc[22:16] : 7'd60;

   // fine cool time (3*err+1500)/50 for err 0..500
   assign nf        = {3'b0, err_i[8:0]} * 12'd3 + 12'd1500;
   assign pf        = {12'b0, nf} * 24'd1311;
   assign fine_cool = pf[22:16];

   // heat time test on the stored pulse: elapsed > floor(ms/1000) <=> elapsed*1000 > ms
   assign elapsed_ms   = {10'b0, state_i.elapsed} * 26'd1000;
   assign heat_time_up = elapsed_ms > {4'b0, state_i.heat_cap};
   assign from_compute = !restart_i && (state_i.phase == PH_COMPUTE);

   // one tick
   always_comb begin
      state_type st;
      rsp_type   rs;
      st             = state_i;
      rs.main_ms     = '0;
      rs.rear_ms     = '0;
      rs.heaters_off = 1'b0;

      // restart first
      if (restart_i) begin
         st.heat_cap = '0;
         st.cool     = 7'd60;
         st.elapsed  = '0;
         st.pending  = 1'b1;
         st.phase    = PH_COOL;
         if (clear_i) begin
            st.integral = '0;
         end
         rs.heaters_off = 1'b1;
      end

      // stability count
      if (near_set && st.stable < 6'd60) begin
         st.stable = st.stable + 6'd1;
      end

      // reference sampling and trend
      if (st.phase == PH_COOL) begin
         if (st.pending) begin
            st.pending   = 1'b0;
            st.reference = temp_i;
         end
      end else if (st.phase == PH_COMPUTE && st.cool != 7'd0) begin
         if (drift > 21'sd50) begin
            st.trend = TR_FAST_FALL;
         end else if (drift > 21'sd8) begin
            st.trend = TR_SLOW_FALL;
         end else if (drift < -21'sd50) begin
            st.trend = TR_FAST_RISE;
         end else if (drift < -21'sd8) begin
            st.trend = TR_SLOW_RISE;
         end else begin
            st.trend = TR_STEADY;
         end
         st.pending = 1'b1;
      end
      rs.trend = st.trend;

      // pulse sizing, cool time and integral
      if (st.phase == PH_COMPUTE) begin
         st.heat_cap = '0;
         if (!cfg_i.enable) begin
            st.cool = 7'd10;
         end else if (err_coarse) begin
            if (st.trend inside {TR_FAST_FALL, TR_SLOW_FALL, TR_STEADY}) begin
               rs.main_ms    = heat_ms;
               rs.rear_ms    = rear_ms;
               st.heat_cap   = heat_cap;
               st.cool       = coarse_cool;
               st.escalation = sat_add8(st.escalation, 4'd1);
            end else if (st.trend inside {TR_SLOW_RISE, TR_FAST_RISE}) begin
               st.cool = 7'd30;
            end
         end else if (!err_neg) begin
            if (st.trend inside {TR_FAST_FALL, TR_SLOW_FALL, TR_STEADY}) begin
               if (st.integral[7]) begin
                  st.integral = '0;
               end
               rs.main_ms  = heat_ms;
               rs.rear_ms  = rear_ms;
               st.heat_cap = heat_cap;
               st.cool     = fine_cool;
               st.no_rise  = sat_add8(st.no_rise, 4'd1);
            end else if (st.trend == TR_SLOW_RISE) begin
               st.slow_rise = sat_add8(st.slow_rise, 4'd1);
               st.cool      = 7'd30;
            end else if (st.trend == TR_FAST_RISE) begin
               st.slow_rise = sat_add8(st.slow_rise, 4'd5);
               st.cool      = 7'd30;
            end
            if (!st.region) begin
               st.cycle  = '0;
               st.region = 1'b1;
            end
            if (st.cycle >= 8'd3) begin
               if (st.slow_rise <= 8'd1 || st.no_rise >= 8'd1) begin
                  st.integral  = ($signed(st.integral) >= 8'sd126) ? 8'd127 :
                                 st.integral + 8'd2;
                  st.slow_rise = '0;
                  st.no_rise   = '0;
               end
               st.cycle = '0;
            end
            st.cycle      = sat_add8(st.cycle, 4'd1);
            st.escalation = '0;
         end else begin
            if (st.region) begin
               st.cycle  = '0;
               st.region = 1'b0;
            end
            if (st.cycle >= 8'd8) begin
               st.integral = ($signed(st.integral) <= -8'sd127) ? 8'h80 :
                             st.integral - 8'd2;
               st.cycle    = '0;
            end
            st.cycle      = sat_add8(st.cycle, 4'd1);
            st.cool       = 7'd60;
            st.escalation = '0;
         end
         st.elapsed = '0;
         st.phase   = PH_HEAT;
      end

      // phase ends
      if (st.phase == PH_HEAT) begin
         if ((!from_compute && heat_time_up) || !err_pos) begin
            st.elapsed = '0;
            if (!err_pos) begin
               st.overshoot = 1'b1;
            end
            rs.heaters_off = 1'b1;
            st.phase       = PH_COOL;
         end
      end else if (st.phase == PH_COOL) begin
         if (st.elapsed >= {9'b0, st.cool} || (st.overshoot && err_pos)) begin
            st.elapsed   = '0;
            st.overshoot = 1'b0;
            st.phase     = PH_COMPUTE;
         end
      end

      if (st.elapsed != 16'hFFFF) begin
         st.elapsed = st.elapsed + 16'd1;
      end

      if (cfg_i.enable) begin
         st.trend = TR_UNDET;
      end

      rs.phase    = phase_code(st.phase);
      rs.integral = st.integral;
      rs.stable   = st.stable;

      state_o = st;
      rsp_o   = rs;
   end

endmodule

@@ rtl/chamber_heat_burst_controller.sv @@
`timescale 1ns / 1ps

// Chamber heat burst controller: one item per one-second temperature tick.
// The req_ channel carries the filtered temperature and the restart and
// clear_integral flags; each accepted item yields exactly one rsp_ item
// with the heater pulses, heaters-off command, phase, trend, integral and
// stability count. The csr_ channel writes the five control registers by
// index; it is always ready and should only be used while no item is in
// flight.
// An accepted item is held in the input register, passes the state update
// into the result register and is presented on rsp_. Throughput is one item
// per cycle while rsp_stall is low, set by the state update, whose longest
// path is the 20 x 24 pulse multiplier followed by the saturating add.
// When the receiver holds rsp_stall high the result register keeps its item
// and one more item can wait in the input register; after that req_stall
// rises until the result is taken.
// Synchronous reset returns all control state and configuration registers
// to their initial values: cooling phase, 60 s cool time, integral zero,
// sampling armed, trend undetermined.
module chamber_heat_burst_controller import chb_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [TEMP_W-1:0]     req_temp_milli,
   input  logic                  req_restart,
   input  logic                  req_clear_integral,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [PULSE_W-1:0]    rsp_main_pulse_ms,
   output logic [PULSE_W-1:0]    rsp_rear_pulse_ms,
   output logic                  rsp_heaters_off,
   output logic [1:0]            rsp_phase,
   output logic [2:0]            rsp_trend,
   output logic [7:0]            rsp_integral,
   output logic [5:0]            rsp_stable_count,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type                 cfg;
   logic                    in_valid_ff;
   logic [TEMP_W-1:0]       in_temp_ff;
   logic signed [ERR_W-1:0] in_err_ff;
   logic signed [ERR_W-1:0] in_err_in;
   logic                    in_restart_ff;
   logic                    in_clear_ff;
   logic                    out_valid_ff;
   rsp_type                 out_ff;
   rsp_type                 out_in;
   state_type               state_ff;
   state_type               state_in;
   logic                    advance;

   chb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .csr_ready (csr_ready),
      .cfg_o     (cfg)
   );

   // pipeline flow control
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   // error against the setpoint, taken with the item
   assign in_err_in = $signed({cfg.setpoint[TEMP_W-1], cfg.setpoint})
                      - $signed({req_temp_milli[TEMP_W-1], req_temp_milli});

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_temp_ff    <= req_temp_milli;
         in_err_ff     <= in_err_in;
         in_restart_ff <= req_restart;
         in_clear_ff   <= req_clear_integral;
      end
   end

   chb_step u_step (
      .cfg_i     (cfg),
      .state_i   (state_ff),
      .temp_i    (in_temp_ff),
      .err_i     (in_err_ff),
      .restart_i (in_restart_ff),
      .clear_i   (in_clear_ff),
      .state_o   (state_in),
      .rsp_o     (out_in)
   );

   // controller state, updated once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_COOL;
         state_ff.elapsed    <= '0;
         state_ff.heat_cap   <= '0;
         state_ff.cool       <= 7'd60;
         state_ff.overshoot  <= 1'b0;
         state_ff.integral   <= '0;
         state_ff.escalation <= '0;
         state_ff.cycle      <= '0;
         state_ff.region     <= 1'b0;
         state_ff.slow_rise  <= '0;
         state_ff.no_rise    <= '0;
         state_ff.reference  <= '0;
         state_ff.pending    <= 1'b1;
         state_ff.trend      <= TR_UNDET;
         state_ff.stable     <= '0;
      end else if (in_valid_ff && advance) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_main_pulse_ms = out_ff.main_ms;
   assign rsp_rear_pulse_ms = out_ff.rear_ms;
   assign rsp_heaters_off   = out_ff.heaters_off;
   assign rsp_phase         = out_ff.phase;
   assign rsp_trend         = out_ff.trend;
   assign rsp_integral      = out_ff.integral;
   assign rsp_stable_count  = out_ff.stable;

endmodule
